@@ hw/rtl/r2fft_pkg.sv @@
// ----------------------------------------------------------------------------
// r2fft_pkg: shared types and constants for the radix-2 FFT block
// Holds the sequencer states and the fixed widths of the result fields.
// ----------------------------------------------------------------------------
package r2fft_pkg;

  localparam int unsigned COEF_BITS  = 26;
  localparam int unsigned INDEX_BITS = 10;
  localparam int unsigned LOG2_BITS  = 4;

  localparam logic KIND_PUSH  = 1'b0;
  localparam logic KIND_FETCH = 1'b1;

  localparam logic STATUS_VALID     = 1'b0;
  localparam logic STATUS_NOT_READY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SWAP_RD,
    ST_SWAP_WR,
    ST_BF_RD,
    ST_BF_MUL,
    ST_BF_ADD,
    ST_BF_WR,
    ST_FETCH
  } fft_state_t;

endpackage

@@ hw/rtl/r2fft_ram.sv @@
// ----------------------------------------------------------------------------
// r2fft_ram: generic dual-port RAM
// Two ports, each with write enable and registered read data.
// ----------------------------------------------------------------------------
module r2fft_ram #(
  parameter int unsigned WIDTH = 52,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     a_we,
  input  logic [$clog2(DEPTH)-1:0] a_addr,
  input  logic [WIDTH-1:0]         a_wdata,
  output logic [WIDTH-1:0]         a_rdata,
  input  logic                     b_we,
  input  logic [$clog2(DEPTH)-1:0] b_addr,
  input  logic [WIDTH-1:0]         b_wdata,
  output logic [WIDTH-1:0]         b_rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // both ports share one process; port b wins on a clash
  always_ff @(posedge clk) begin
    if (a_we) begin
      mem[a_addr] <= a_wdata;
    end
    if (b_we) begin
      mem[b_addr] <= b_wdata;
    end
    a_rdata <= mem[a_addr];
    b_rdata <= mem[b_addr];
  end
endmodule

@@ hw/rtl/r2fft_twiddle.sv @@
// ----------------------------------------------------------------------------
// r2fft_twiddle: twiddle factor generator
// Registered cos/-sin of 2*pi*j/PMAX, computed at elaboration into a table.
// ----------------------------------------------------------------------------
module r2fft_twiddle #(
  parameter int unsigned PMAX_LOG2    = 10,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  logic                                  clk,
  input  logic [(PMAX_LOG2 > 1 ? PMAX_LOG2-2 : 0):0] idx,
  output logic signed [TWIDDLE_BITS-1:0]        w_re,
  output logic signed [TWIDDLE_BITS-1:0]        w_im
);
  localparam int unsigned HALF = 2 ** (PMAX_LOG2 - 1);
  localparam real         PI   = 3.14159265358979323846;
  localparam real         LIM  = real'((2 ** (TWIDDLE_BITS - 1)) - 1);
  localparam real         SCL  = real'(2 ** (TWIDDLE_BITS - 1));
  localparam real         STEP = 2.0 * PI / real'(2 * HALF);

  function automatic logic signed [TWIDDLE_BITS-1:0] quant(input real v);
    real a;
    real r;
    a = (v < 0.0) ? -v : v;
    r = $floor(a * SCL + 0.5);
    if (r > LIM) begin
      r = LIM;
    end
    return (v < 0.0) ? -TWIDDLE_BITS'($rtoi(r)) : TWIDDLE_BITS'($rtoi(r));
  endfunction

  logic signed [TWIDDLE_BITS-1:0] rom_re [HALF];
  logic signed [TWIDDLE_BITS-1:0] rom_im [HALF];

  for (genvar k = 0; k < HALF; k++) begin : g_rom
    assign rom_re[k] = quant($cos(real'(k) * STEP));
    assign rom_im[k] = quant(-$sin(real'(k) * STEP));
  end

  always_ff @(posedge clk) begin
    w_re <= rom_re[idx[PMAX_LOG2-2:0]];
    w_im <= rom_im[idx[PMAX_LOG2-2:0]];
  end
endmodule

@@ hw/rtl/radix2_fft_real_input.sv @@
// ----------------------------------------------------------------------------
// radix2_fft_real_input: in-place radix-2 DIT FFT of a real frame
// Loads samples, bit-reverses, runs log2 N butterfly stages through one
// dual-port working RAM, then returns coefficients one per fetch item.
// ----------------------------------------------------------------------------
//
//  channel   direction  handshake                 fields
//  -------   ---------  ------------------------  ------------------------------
//  item in   in         start & !busy             kind, sample
//  result    out        done (one cycle)          coef_re, coef_im, coef_index,
//                                                 last_coef, status
//  config    in         log2_size_we              log2_size_wdata
//
//  A push is taken while idle; the push completing a frame then holds busy
//  for the reorder pass (a read and a write state per entry, N entries) and
//  L*N/2 butterflies, each through the read, multiply, add and write states
//  of the single RAM read-modify-write loop.
//  A valid fetch holds busy in the fetch state while the RAM read returns,
//  and done is registered from that state; a fetch before the frame is
//  complete does not raise busy and gives its result on the next cycle.
//  Reset clears the control state; the working RAM is left uninitialised.
//  The receiver cannot stall: each result shows for exactly one cycle.
//
module radix2_fft_real_input #(
  parameter int unsigned POINTS       = 1024,
  parameter int unsigned SAMPLE_BITS  = 16,
  parameter int unsigned TWIDDLE_BITS = 16
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic                                      kind,
  input  logic signed [SAMPLE_BITS-1:0]             sample,
  input  logic                                      log2_size_we,
  input  logic [r2fft_pkg::LOG2_BITS-1:0]           log2_size_wdata,
  output logic                                      done,
  output logic signed [r2fft_pkg::COEF_BITS-1:0]    coef_re,
  output logic signed [r2fft_pkg::COEF_BITS-1:0]    coef_im,
  output logic [r2fft_pkg::INDEX_BITS-1:0]          coef_index,
  output logic                                      last_coef,
  output logic                                      status
);
  import r2fft_pkg::*;

  // largest power of two not above POINTS
  localparam int unsigned MAXL    = $clog2(POINTS + 1) - 1;
  localparam int unsigned PMAX    = 2 ** MAXL;
  localparam int unsigned QUARTER = PMAX / 4;
  localparam int unsigned AW      = (MAXL < 1) ? 1 : MAXL;
  localparam int unsigned DW      = SAMPLE_BITS + MAXL;
  localparam int unsigned TIW     = (MAXL > 1) ? MAXL - 1 : 1;
  localparam int unsigned PW      = DW + TWIDDLE_BITS;
  localparam int unsigned FRAC    = TWIDDLE_BITS - 1;
  localparam int unsigned SW      = $clog2(MAXL + 1);

  fft_state_t state, state_next;

  logic [LOG2_BITS-1:0] log2_size;
  logic [AW:0]          load_count;
  logic [AW-1:0]        read_pointer;
  logic                 results_ready;
  logic [SW-1:0]        frame_log2;

  // sequencer counters
  logic [AW-1:0] idx;      // reorder index / butterfly counter
  logic [SW-1:0] stage;    // 1..L while running, L+1 after the last stage
  logic [AW-1:0] nmask;    // N-1 of the frame being processed

  // RAM ports
  logic          a_we, b_we;
  logic [AW-1:0] a_addr, b_addr;
  logic [2*DW-1:0] a_wdata, b_wdata, a_rdata, b_rdata;

  r2fft_ram #(.WIDTH(2 * DW), .DEPTH(PMAX)) u_ram (
    .clk, .a_we, .a_addr, .a_wdata, .a_rdata, .b_we, .b_addr, .b_wdata, .b_rdata
  );

  // length clamp
  logic [SW-1:0] cur_log2;
  always_comb begin
    if (log2_size == '0) begin
      cur_log2 = SW'(1);
    end else if (32'(log2_size) > MAXL) begin
      cur_log2 = SW'(MAXL);
    end else begin
      cur_log2 = SW'(log2_size);
    end
  end

  // bit reversal of idx over frame_log2 bits
  logic [AW-1:0] rev_idx;
  always_comb begin
    rev_idx = '0;
    for (int b = 0; b < AW; b++) begin
      if (b < 32'(frame_log2)) begin
        rev_idx[32'(frame_log2) - 1 - b] = idx[b];
      end
    end
  end

  // butterfly addressing: insert 0 at bit stage-1 of idx
  logic [AW-1:0] half_bit, low_mask, e_addr, o_addr;
  logic [TIW:0]  tw_idx;
  always_comb begin
    half_bit = AW'(1) << (stage - SW'(1));
    low_mask = half_bit - AW'(1);
    e_addr   = ((idx & ~low_mask) << 1) | (idx & low_mask);
    o_addr   = e_addr | half_bit;
    tw_idx   = (TIW + 1)'(32'(idx & low_mask) << (MAXL - 32'(stage)));
  end

  logic signed [TWIDDLE_BITS-1:0] w_re, w_im;
  r2fft_twiddle #(.PMAX_LOG2(MAXL), .TWIDDLE_BITS(TWIDDLE_BITS)) u_tw (
    .clk, .idx(tw_idx[TIW-1:0]), .w_re, .w_im
  );

  // registered tw index class (trivial twiddles)
  logic tw_zero, tw_quarter;
  always_ff @(posedge clk) begin
    if (state == ST_BF_RD) begin
      tw_zero    <= (tw_idx == '0);
      tw_quarter <= (PMAX >= 4) && (32'(tw_idx) == QUARTER);
    end
  end

  // butterfly datapath
  logic signed [DW-1:0] er, ei, orr, oii;
  assign er  = a_rdata[2*DW-1:DW];
  assign ei  = a_rdata[DW-1:0];
  assign orr = b_rdata[2*DW-1:DW];
  assign oii = b_rdata[DW-1:0];

  logic signed [DW-1:0] e_re_q, e_im_q;
  logic signed [PW-1:0] p_rr, p_ii, p_ir, p_ri;
  logic signed [DW-1:0] o_re_q, o_im_q;

  // half-away rounding of a product to data scale
  function automatic logic signed [DW+1:0] rnd(input logic signed [PW-1:0] p);
    logic [PW-1:0] m;
    logic [PW-1:0] r;
    m = p[PW-1] ? PW'(-p) : PW'(p);
    r = (m + (PW'(1) << (FRAC - 1))) >> FRAC;
    return p[PW-1] ? -(DW + 2)'(r) : (DW + 2)'(r);
  endfunction

  always_ff @(posedge clk) begin
    if (state == ST_BF_MUL) begin
      e_re_q <= er;
      e_im_q <= ei;
      o_re_q <= orr;
      o_im_q <= oii;
      p_rr <= PW'(orr) * PW'(w_re);
      p_ii <= PW'(oii) * PW'(w_im);
      p_ir <= PW'(oii) * PW'(w_re);
      p_ri <= PW'(orr) * PW'(w_im);
    end
  end

  logic signed [DW+2:0] tr, ti, sum_re, sum_im, dif_re, dif_im;
  logic signed [DW-1:0] up_re, up_im, lo_re, lo_im;

  function automatic logic signed [DW-1:0] sat(input logic signed [DW+2:0] v,
                                               input logic [SW-1:0] s);
    logic signed [DW+2:0] lim;
    lim = (DW + 3)'(1) <<< (SAMPLE_BITS + 32'(s) - 1);
    if (v > lim - 1) begin
      return DW'(lim - 1);
    end else if (v < -lim) begin
      return DW'(-lim);
    end
    return DW'(v);
  endfunction

  always_comb begin
    if (tw_zero) begin
      tr = (DW + 3)'(o_re_q);
      ti = (DW + 3)'(o_im_q);
    end else if (tw_quarter) begin
      tr = (DW + 3)'(o_im_q);
      ti = -(DW + 3)'(o_re_q);
    end else begin
      tr = (DW + 3)'(rnd(p_rr)) - (DW + 3)'(rnd(p_ii));
      ti = (DW + 3)'(rnd(p_ir)) + (DW + 3)'(rnd(p_ri));
    end
    sum_re = (DW + 3)'(e_re_q) + tr;
    sum_im = (DW + 3)'(e_im_q) + ti;
    dif_re = (DW + 3)'(e_re_q) - tr;
    dif_im = (DW + 3)'(e_im_q) - ti;
  end

  always_ff @(posedge clk) begin
    if (state == ST_BF_ADD) begin
      up_re <= sat(sum_re, stage);
      up_im <= sat(sum_im, stage);
      lo_re <= sat(dif_re, stage);
      lo_im <= sat(dif_im, stage);
    end
  end

  // hold the addresses of the butterfly and swap in flight
  logic [AW-1:0] e_hold, o_hold;

  logic [AW-1:0] last_bf;
  assign last_bf = nmask >> 1;

  // next state and RAM control
  always_comb begin
    state_next = state;
    a_we = 1'b0;
    b_we = 1'b0;
    a_addr = e_hold;
    b_addr = o_hold;
    a_wdata = {up_re, up_im};
    b_wdata = {lo_re, lo_im};
    busy = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (start && kind == KIND_PUSH) begin
          a_we    = 1'b1;
          a_addr  = results_ready ? '0 : load_count[AW-1:0];
          a_wdata = {DW'(sample), DW'(0)};
          if ((results_ready ? (AW + 1)'(1) : load_count + 1'b1)
              >= ((AW + 1)'(1) << cur_log2)) begin
            state_next = ST_SWAP_RD;
          end
        end else if (start && kind == KIND_FETCH && results_ready) begin
          a_addr     = read_pointer;
          state_next = ST_FETCH;
        end
      end
      ST_FETCH: begin
        state_next = ST_IDLE;
      end
      ST_SWAP_RD: begin
        a_addr = idx;
        b_addr = rev_idx;
        state_next = ST_SWAP_WR;
      end
      ST_SWAP_WR: begin
        // write with imaginary parts cleared: idx always, and rev too, exchanged, when rev > idx
        a_we    = 1'b1;
        b_we    = (o_hold > e_hold);
        a_wdata = (o_hold > e_hold) ? {b_rdata[2*DW-1:DW], DW'(0)}
                                    : {a_rdata[2*DW-1:DW], DW'(0)};
        b_wdata = {a_rdata[2*DW-1:DW], DW'(0)};
        if (idx == nmask) begin
          state_next = ST_BF_RD;
        end else begin
          state_next = ST_SWAP_RD;
        end
      end
      ST_BF_RD: begin
        a_addr = e_addr;
        b_addr = o_addr;
        state_next = ST_BF_MUL;
      end
      ST_BF_MUL: begin
        state_next = ST_BF_ADD;
      end
      ST_BF_ADD: begin
        state_next = ST_BF_WR;
      end
      ST_BF_WR: begin
        a_we = 1'b1;
        b_we = 1'b1;
        if (idx == last_bf && stage == frame_log2) begin
          state_next = ST_IDLE;
        end else begin
          state_next = ST_BF_RD;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      log2_size     <= LOG2_BITS'(10);
      load_count    <= '0;
      read_pointer  <= '0;
      results_ready <= 1'b0;
      frame_log2    <= SW'(1);
      idx           <= '0;
      stage         <= SW'(1);
      nmask         <= '0;
    end else begin
      if (log2_size_we) begin
        log2_size <= log2_size_wdata;
      end
      unique case (state)
        ST_IDLE: begin
          if (start && kind == KIND_PUSH) begin
            if (state_next == ST_SWAP_RD) begin
              load_count    <= '0;
              results_ready <= 1'b0;
              frame_log2    <= cur_log2;
              nmask         <= AW'((32'(1) << cur_log2) - 1);
              idx           <= '0;
              stage         <= SW'(1);
            end else begin
              load_count    <= results_ready ? (AW + 1)'(1) : load_count + 1'b1;
              results_ready <= 1'b0;
            end
            read_pointer <= '0;
          end else if (start && kind == KIND_FETCH) begin
            if (results_ready) begin
              read_pointer <= read_pointer + 1'b1 & nmask;
            end
          end
        end
        ST_SWAP_WR: begin
          idx <= (idx == nmask) ? '0 : idx + 1'b1;
        end
        ST_BF_WR: begin
          if (idx == last_bf) begin
            idx   <= '0;
            stage <= stage + 1'b1;
            if (stage == frame_log2) begin
              results_ready <= 1'b1;
              read_pointer  <= '0;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // addresses in flight, fetch index
  logic [AW-1:0] fetch_p;
  always_ff @(posedge clk) begin
    if (state == ST_SWAP_RD) begin
      e_hold <= idx;
      o_hold <= rev_idx;
    end else if (state == ST_BF_RD) begin
      e_hold <= e_addr;
      o_hold <= o_addr;
    end
    if (state == ST_IDLE) begin
      fetch_p <= read_pointer;
    end
  end

  // result register: capture the coefficient as the RAM read returns, or
  // zero fields with status not ready for an early fetch; strobe done once
  always_ff @(posedge clk) begin
    if (rst) begin
      done       <= 1'b0;
      coef_re    <= '0;
      coef_im    <= '0;
      coef_index <= '0;
      last_coef  <= 1'b0;
      status     <= STATUS_VALID;
    end else if (state == ST_FETCH) begin
      done       <= 1'b1;
      coef_re    <= COEF_BITS'(signed'(a_rdata[2*DW-1:DW]));
      coef_im    <= COEF_BITS'(signed'(a_rdata[DW-1:0]));
      coef_index <= INDEX_BITS'(fetch_p);
      last_coef  <= (fetch_p == nmask);
      status     <= STATUS_VALID;
    end else if (state == ST_IDLE && start && kind == KIND_FETCH && !results_ready) begin
      done       <= 1'b1;
      coef_re    <= '0;
      coef_im    <= '0;
      coef_index <= '0;
      last_coef  <= 1'b0;
      status     <= STATUS_NOT_READY;
    end else begin
      done <= 1'b0;
    end
  end
endmodule
